/* rtl/core/reed_solomon_parity_encoder_core_assert.svh */
// Assertion macros for the encoder core RTL.
`ifndef REED_SOLOMON_PARITY_ENCODER_CORE_ASSERT_SVH
`define REED_SOLOMON_PARITY_ENCODER_CORE_ASSERT_SVH

// Clocked assertion, muted while reset is high.
`define RSPE_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Clocked assertion that also holds through reset.
`define RSPE_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

/* rtl/core/rspe_pkg.sv */
`default_nettype none

package rspe_pkg;

  localparam int FIELD_SIZE  = 256;
  localparam int FIELD_ORDER = FIELD_SIZE - 1;

  localparam int DEF_MAX_CHECK_PAIRS = 16;
  localparam int DEF_FIELD_POLY      = 285;

  localparam int DATA_W     = 8;
  localparam int CP_W       = 5;
  localparam int IDX_OUT_W  = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_PAIRS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ROOT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MESSAGE_LENGTH = 2'd2;

  localparam logic [CP_W-1:0]   RST_CHECK_PAIRS    = 5'd16;
  localparam logic [DATA_W-1:0] RST_FIRST_ROOT     = 8'd0;
  localparam logic [DATA_W-1:0] RST_MESSAGE_LENGTH = 8'd223;

  typedef enum logic [1:0] {
    GEN_IDLE,
    GEN_ROOT,
    GEN_COEF
  } gen_state_t;

  typedef struct packed {
    logic step;
    logic clear;
  } lfsr_ctrl_t;

  // GF(256) multiply, shift-and-add with reduction by poly.
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
                                        input logic [8:0] poly);
    logic [8:0] x;
    logic [7:0] acc;
    x   = {1'b0, a};
    acc = 8'h00;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) begin
        acc = acc ^ x[7:0];
      end
      x = {x[7:0], 1'b0};
      if (x[8]) begin
        x = x ^ poly;
      end
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/rspe_gen.sv */
`default_nettype none

module rspe_gen #(
  parameter int MAX_CHECK_PAIRS = rspe_pkg::DEF_MAX_CHECK_PAIRS,
  parameter int FIELD_POLY      = rspe_pkg::DEF_FIELD_POLY,
  localparam int STAGES = 2 * MAX_CHECK_PAIRS,
  localparam int SW     = $clog2(MAX_CHECK_PAIRS + 1) + 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [rspe_pkg::CP_W-1:0]     check_pairs,
  input  wire logic [rspe_pkg::DATA_W-1:0]   first_root,
  input  wire logic [rspe_pkg::DATA_W-1:0]   message_length,
  output logic                               busy,
  output logic [STAGES-1:0][7:0]             coef,
  output logic [SW-1:0]                      active_stages,
  output logic [7:0]                         active_length
);
  import rspe_pkg::*;

  localparam int         TW   = SW - 1;
  localparam logic [8:0] POLY = 9'(FIELD_POLY);

  gen_state_t state, state_next;

  logic [7:0]              root;
  logic [7:0]              root_cnt;
  logic [SW-1:0]           coef_cnt;
  logic [STAGES-1:0][7:0]  h;
  logic [STAGES-1:0][7:0]  h_lower;
  logic [STAGES-1:0][7:0]  h_step;

  logic [TW-1:0] t_clamp;
  logic [SW-1:0] stages_clamp;
  logic [SW-1:0] offset;
  logic [8:0]    max_len;
  logic [7:0]    len_clamp;
  logic [7:0]    b0;

  logic load, root_step, coef_step;

  // clamp config
  always_comb begin
    if (check_pairs == '0) begin
      t_clamp = TW'(1);
    end else if (32'(check_pairs) > 32'(MAX_CHECK_PAIRS)) begin
      t_clamp = TW'(MAX_CHECK_PAIRS);
    end else begin
      t_clamp = TW'(check_pairs);
    end
    stages_clamp = {t_clamp, 1'b0};
    offset       = SW'(STAGES) - stages_clamp;
    max_len      = 9'(FIELD_ORDER) - 9'(stages_clamp);
    if (message_length == '0) begin
      len_clamp = 8'd1;
    end else if ({1'b0, message_length} > max_len) begin
      len_clamp = max_len[7:0];
    end else begin
      len_clamp = message_length;
    end
    b0 = (first_root == 8'(FIELD_ORDER)) ? 8'd0 : first_root;
  end

  // one root factor folded into all coefficients at once
  assign h_lower = {h[STAGES-2:0], 8'h00};

  always_comb begin
    for (int q = 0; q < STAGES; q++) begin
      h_step[q] = h_lower[q] ^ gf_mul(h[q], root, POLY);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= GEN_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    load       = 1'b0;
    root_step  = 1'b0;
    coef_step  = 1'b0;
    case (state)
      GEN_IDLE: begin
        if (start) begin
          load       = 1'b1;
          state_next = GEN_ROOT;
        end
      end
      GEN_ROOT: begin
        if (root_cnt == '0) begin
          state_next = GEN_COEF;
        end else begin
          root_step = 1'b1;
        end
      end
      GEN_COEF: begin
        if (coef_cnt == '0) begin
          state_next = GEN_IDLE;
        end else begin
          coef_step = 1'b1;
        end
      end
      default: begin
        state_next = GEN_IDLE;
      end
    endcase
  end

  assign busy = (state != GEN_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      active_stages <= SW'(STAGES);
      active_length <= 8'd1;
    end else if (load) begin
      active_stages <= stages_clamp;
      active_length <= len_clamp;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      root     <= 8'd1;
      root_cnt <= b0;
      coef_cnt <= stages_clamp;
      for (int q = 0; q < STAGES; q++) begin
        h[q] <= (SW'(q) == offset) ? 8'd1 : 8'd0;
      end
    end else if (root_step) begin
      root     <= gf_mul(root, 8'd2, POLY);
      root_cnt <= root_cnt - 8'd1;
    end else if (coef_step) begin
      h        <= h_step;
      root     <= gf_mul(root, 8'd2, POLY);
      coef_cnt <= coef_cnt - SW'(1);
    end
  end

  assign coef = h;

endmodule

`default_nettype wire

/* rtl/core/rspe_lfsr.sv */
`default_nettype none

module rspe_lfsr #(
  parameter int MAX_CHECK_PAIRS = rspe_pkg::DEF_MAX_CHECK_PAIRS,
  parameter int FIELD_POLY      = rspe_pkg::DEF_FIELD_POLY,
  localparam int STAGES = 2 * MAX_CHECK_PAIRS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire rspe_pkg::lfsr_ctrl_t         ctrl,
  input  wire logic [rspe_pkg::DATA_W-1:0]  data_byte,
  input  wire logic [STAGES-1:0][7:0]       coef,
  output logic [STAGES-1:0][7:0]            p_next
);
  import rspe_pkg::*;

  localparam logic [8:0] POLY = 9'(FIELD_POLY);

  logic [STAGES-1:0][7:0] p;
  logic [STAGES-1:0][7:0] p_lower;
  logic [7:0]             fb;

  // active stages sit at the top; unused low stages stay zero
  assign fb      = p[STAGES-1] ^ data_byte;
  assign p_lower = {p[STAGES-2:0], 8'h00};

  always_comb begin
    for (int q = 0; q < STAGES; q++) begin
      p_next[q] = p_lower[q] ^ gf_mul(coef[q], fb, POLY);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p <= '0;
    end else if (ctrl.step) begin
      p <= ctrl.clear ? '0 : p_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/rspe_obuf.sv */
`default_nettype none

module rspe_obuf #(
  parameter int MAX_CHECK_PAIRS = rspe_pkg::DEF_MAX_CHECK_PAIRS,
  localparam int STAGES = 2 * MAX_CHECK_PAIRS,
  localparam int SW     = $clog2(MAX_CHECK_PAIRS + 1) + 1
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             load,
  input  wire logic [STAGES-1:0][7:0]           load_data,
  input  wire logic [SW-1:0]                    load_count,
  input  wire logic                             parity_ready,
  output logic                                  parity_valid,
  output logic [rspe_pkg::DATA_W-1:0]           parity_byte,
  output logic [rspe_pkg::IDX_OUT_W-1:0]        parity_index,
  output logic                                  last_parity
);
  import rspe_pkg::*;

  logic [STAGES-1:0][7:0]   hold;
  logic [SW-1:0]            remaining;
  logic [SW-1:0]            idx_full;
  logic [SW+IDX_OUT_W-1:0]  idx_wide;
  logic                     pop;

  assign parity_valid = (remaining != '0);
  assign pop          = parity_valid && parity_ready;
  assign idx_full     = remaining - SW'(1);
  assign idx_wide     = {{IDX_OUT_W{1'b0}}, idx_full};
  assign parity_byte  = hold[STAGES-1];
  assign parity_index = idx_wide[IDX_OUT_W-1:0];
  assign last_parity  = (remaining == SW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
    end else if (load) begin
      remaining <= load_count;
    end else if (pop) begin
      remaining <= remaining - SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold <= load_data;
    end else if (pop) begin
      hold <= {hold[STAGES-2:0], 8'h00};
    end
  end

endmodule

`default_nettype wire

/* rtl/core/reed_solomon_parity_encoder_core.sv */
// Latency: the first parity beat is offered the cycle after the last data beat is taken.
// One beat per cycle per port while its ready is high; 2t parity beats per codeword.
// A codeword's last data beat waits while the previous codeword's parity still drains.
// Generator derivation after reset or a config write holds data_ready low.
// Reset (rst, synchronous): parity register zero, config to t=16, b0=0, length 223,
// then one derivation pass.
`default_nettype none
`include "reed_solomon_parity_encoder_core_assert.svh"

module reed_solomon_parity_encoder_core #(
  parameter int MAX_CHECK_PAIRS = rspe_pkg::DEF_MAX_CHECK_PAIRS,
  parameter int FIELD_POLY      = rspe_pkg::DEF_FIELD_POLY
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // config write port
  input  wire logic                             cfg_write_enable,
  input  wire logic [rspe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rspe_pkg::CFG_DATA_W-1:0]  cfg_data,
  // message beats
  input  wire logic                             data_valid,
  output logic                                  data_ready,
  input  wire logic [rspe_pkg::DATA_W-1:0]      data_byte,
  // parity beats
  output logic                                  parity_valid,
  input  wire logic                             parity_ready,
  output logic [rspe_pkg::DATA_W-1:0]           parity_byte,
  output logic [rspe_pkg::IDX_OUT_W-1:0]        parity_index,
  output logic                                  last_parity
);
  import rspe_pkg::*;

  localparam int STAGES = 2 * MAX_CHECK_PAIRS;
  localparam int SW     = $clog2(MAX_CHECK_PAIRS + 1) + 1;

  // config registers, stored at once; derived values only refresh between codewords
  logic [CP_W-1:0]   check_pairs;
  logic [DATA_W-1:0] first_root;
  logic [DATA_W-1:0] message_length;

  logic       derive_pending;
  logic       cfg_hit;
  logic [7:0] byte_count;

  logic                   gen_start;
  logic                   gen_busy;
  logic [STAGES-1:0][7:0] gen_coef;
  logic [SW-1:0]          active_stages;
  logic [7:0]             active_length;

  logic                   accept;
  logic                   completing;
  lfsr_ctrl_t             lfsr_ctrl;
  logic [STAGES-1:0][7:0] p_next;

  assign cfg_hit = cfg_write_enable && ((cfg_index == CFG_CHECK_PAIRS) ||
                                        (cfg_index == CFG_FIRST_ROOT) ||
                                        (cfg_index == CFG_MESSAGE_LENGTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      check_pairs    <= RST_CHECK_PAIRS;
      first_root     <= RST_FIRST_ROOT;
      message_length <= RST_MESSAGE_LENGTH;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        CFG_CHECK_PAIRS:    check_pairs    <= cfg_data[CP_W-1:0];
        CFG_FIRST_ROOT:     first_root     <= cfg_data[DATA_W-1:0];
        CFG_MESSAGE_LENGTH: message_length <= cfg_data[DATA_W-1:0];
        default: ;
      endcase
    end
  end

  // A write during a codeword waits here until the codeword closes.
  // A write in the start cycle re-arms, so the newest values always win.
  assign gen_start = derive_pending && (byte_count == '0) && !gen_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      derive_pending <= 1'b1;
    end else if (cfg_hit) begin
      derive_pending <= 1'b1;
    end else if (gen_start) begin
      derive_pending <= 1'b0;
    end
  end

  rspe_gen #(
    .MAX_CHECK_PAIRS (MAX_CHECK_PAIRS),
    .FIELD_POLY      (FIELD_POLY)
  ) u_gen (
    .clk            (clk),
    .rst            (rst),
    .start          (gen_start),
    .check_pairs    (check_pairs),
    .first_root     (first_root),
    .message_length (message_length),
    .busy           (gen_busy),
    .coef           (gen_coef),
    .active_stages  (active_stages),
    .active_length  (active_length)
  );

  // Byte accounting. The closing beat needs an empty parity buffer.
  assign completing = (byte_count == (active_length - 8'd1));
  assign data_ready = !gen_busy &&
                      !(derive_pending && (byte_count == '0)) &&
                      !(completing && parity_valid);
  assign accept     = data_valid && data_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else if (accept) begin
      byte_count <= completing ? 8'd0 : (byte_count + 8'd1);
    end
  end

  assign lfsr_ctrl.step  = accept;
  assign lfsr_ctrl.clear = completing;

  rspe_lfsr #(
    .MAX_CHECK_PAIRS (MAX_CHECK_PAIRS),
    .FIELD_POLY      (FIELD_POLY)
  ) u_lfsr (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (lfsr_ctrl),
    .data_byte (data_byte),
    .coef      (gen_coef),
    .p_next    (p_next)
  );

  // Final parity is snapshotted into the drain buffer while the LFSR clears.
  rspe_obuf #(
    .MAX_CHECK_PAIRS (MAX_CHECK_PAIRS)
  ) u_obuf (
    .clk          (clk),
    .rst          (rst),
    .load         (accept && completing),
    .load_data    (p_next),
    .load_count   (active_stages),
    .parity_ready (parity_ready),
    .parity_valid (parity_valid),
    .parity_byte  (parity_byte),
    .parity_index (parity_index),
    .last_parity  (last_parity)
  );

  `RSPE_ASSERT(a_count_in_range, clk, rst, byte_count < active_length, "byte count past length")
  `RSPE_ASSERT(a_gen_between_words, clk, rst, gen_busy |-> (byte_count == '0), "derive mid-codeword")
  `RSPE_ASSERT(a_parity_follows, clk, rst, (accept && completing) |=> parity_valid, "no parity after last beat")
  `RSPE_ASSERT_ALWAYS(a_reset_derives, clk, rst |=> !data_ready, "data taken before derive")

endmodule

`default_nettype wire

/* sim/tb_reed_solomon_parity_encoder_core.sv */
`timescale 1ns / 100ps

module tb_reed_solomon_parity_encoder_core;
  import rspe_pkg::*;

  localparam int PAIRS_MAX   = DEF_MAX_CHECK_PAIRS;
  localparam int STAGES_MAX  = 2 * PAIRS_MAX;
  localparam int ITEM_TARGET = 410;
  // Longest legal silence: derivation with b0=254, t=16, plus a long sender gap
  // and a long receiver stall. Taken many times over.
  localparam int STALL_LIMIT = 6000;
  // Index 3 is not mapped to any register; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // One expected parity beat.
  typedef struct packed {
    logic [DATA_W-1:0]    sym;
    logic [IDX_OUT_W-1:0] pos;
    logic                 tail;
  } parity_beat_t;

  // DUT inputs start at known values.
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write_enable = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  data_valid = 1'b0;
  logic                  data_ready;
  logic [DATA_W-1:0]     data_byte = '0;
  logic                  parity_valid;
  logic                  parity_ready = 1'b0;
  logic [DATA_W-1:0]     parity_byte;
  logic [IDX_OUT_W-1:0]  parity_index;
  logic                  last_parity;

  // GF(256) log / antilog tables, built once at time zero.
  logic [7:0] gf_exp [0:254];
  int         gf_log [0:255];

  // Shadow of the config registers as written.
  logic [CP_W-1:0] reg_pairs;
  logic [7:0]      reg_root;
  logic [7:0]      reg_length;

  // Encoder state as the shadow sees it: clamped t and length, generator,
  // parity LFSR and position inside the current codeword.
  int         eff_pairs;
  int         eff_length;
  int         msg_count;
  logic [7:0] gen_poly [0:STAGES_MAX];
  logic [7:0] lfsr_stage [0:STAGES_MAX-1];

  logic [7:0]   msg_bytes_q[$];      // message bytes waiting for the driver
  parity_beat_t parity_expect_q[$];  // parity beats predicted, not yet seen

  bit burst_mode;  // set per phase: no gaps and no stalls on either side
  int items_queued;
  int codewords_done;
  int beats_seen;
  int mismatch_count;
  int config_writes;
  int idle_cycles;
  int send_gap;
  int recv_stall;

  reed_solomon_parity_encoder_core dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .data_valid       (data_valid),
    .data_ready       (data_ready),
    .data_byte        (data_byte),
    .parity_valid     (parity_valid),
    .parity_ready     (parity_ready),
    .parity_byte      (parity_byte),
    .parity_index     (parity_index),
    .last_parity      (last_parity)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // GF(256) arithmetic and generator
  // ---------------------------------------------------------------------

  // Powers of alpha = x, reduced by the field polynomial.
  task automatic build_field();
    logic [8:0] v;
    v = 9'h001;
    for (int e = 0; e < 255; e++) begin
      gf_exp[e] = v[7:0];
      gf_log[v[7:0]] = e;
      v = v << 1;
      if (v[8]) v = v ^ 9'(DEF_FIELD_POLY);
    end
  endtask

  function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
    if (a == 8'h00 || b == 8'h00) return 8'h00;
    return gf_exp[(gf_log[a] + gf_log[b]) % 255];
  endfunction

  // Clamp t and length, then multiply out prod (x - alpha^(b0+r)), r < 2t.
  // b0 is taken mod 255, so a root of 255 behaves as 0.
  function automatic void rebuild_generator();
    logic [7:0] root;
    int         expo;
    eff_pairs = (reg_pairs < 1) ? 1 : (reg_pairs > PAIRS_MAX) ? PAIRS_MAX : int'(reg_pairs);
    eff_length = (reg_length < 1) ? 1 : int'(reg_length);
    if (eff_length > 255 - 2 * eff_pairs) eff_length = 255 - 2 * eff_pairs;
    expo = reg_root % 255;
    for (int k = 0; k <= STAGES_MAX; k++) gen_poly[k] = 8'h00;
    gen_poly[0] = 8'h01;
    for (int r = 0; r < 2 * eff_pairs; r++) begin
      root = gf_exp[(expo + r) % 255];
      for (int k = r + 1; k > 0; k--) begin
        gen_poly[k] = gen_poly[k-1] ^ gf_times(gen_poly[k], root);
      end
      gen_poly[0] = gf_times(gen_poly[0], root);
    end
  endfunction

  // One message byte through the LFSR. On the last byte of a codeword the
  // 2t parity beats are queued highest stage first, the LFSR clears and any
  // config written meanwhile takes effect.
  function automatic void encode_byte(input logic [7:0] d);
    logic [7:0] fb;
    int         top;
    top = 2 * eff_pairs - 1;
    fb = lfsr_stage[top] ^ d;
    for (int j = top; j > 0; j--) begin
      lfsr_stage[j] = lfsr_stage[j-1] ^ gf_times(gen_poly[j], fb);
    end
    lfsr_stage[0] = gf_times(gen_poly[0], fb);
    msg_count++;
    if (msg_count < eff_length) return;
    for (int j = top; j >= 0; j--) begin
      parity_expect_q.push_back('{sym: lfsr_stage[j], pos: IDX_OUT_W'(j), tail: (j == 0)});
    end
    foreach (lfsr_stage[k]) lfsr_stage[k] = 8'h00;
    msg_count = 0;
    codewords_done++;
    rebuild_generator();
  endfunction

  // ---------------------------------------------------------------------
  // Random shaping
  // ---------------------------------------------------------------------

  // Mostly back to back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Bias toward all-zero and all-one symbols.
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Legal t mostly; now and then zero or above the maximum (clamped).
  function automatic logic [CP_W-1:0] pick_pairs();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return CP_W'($urandom_range(PAIRS_MAX + 1, 31));
    if (r == 1) return '0;
    return CP_W'($urandom_range(1, PAIRS_MAX));
  endfunction

  // Short codewords keep the run small; zero clamps to one.
  function automatic logic [7:0] pick_length();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 8'h00;
    if (r < 3) return 8'($urandom_range(13, 40));
    return 8'($urandom_range(1, 12));
  endfunction

  // ---------------------------------------------------------------------
  // Sequencing helpers (used from the stimulus process only)
  // ---------------------------------------------------------------------

  // Register write; the shadow is updated at once since the DUT is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_write_enable <= 1'b1;
    cfg_index        <= idx;
    cfg_data         <= val;
    case (idx)
      CFG_CHECK_PAIRS:    reg_pairs = val[CP_W-1:0];
      CFG_FIRST_ROOT:     reg_root = val;
      CFG_MESSAGE_LENGTH: reg_length = val;
      default: ;
    endcase
    rebuild_generator();
    config_writes++;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
  endtask

  task automatic set_code(input logic [7:0] pairs, input logic [7:0] root,
                          input logic [7:0] len);
    write_reg(CFG_CHECK_PAIRS, pairs);
    write_reg(CFG_FIRST_ROOT, root);
    write_reg(CFG_MESSAGE_LENGTH, len);
  endtask

  task automatic feed(input logic [7:0] b);
    msg_bytes_q.push_back(b);
    items_queued++;
  endtask

  task automatic queue_codewords(input int count);
    for (int c = 0; c < count; c++) begin
      for (int b = 0; b < eff_length; b++) feed(pick_byte());
    end
  endtask

  // Everything sent and every parity beat back, then the DUT is left idle so
  // it has settled before the next register write.
  task automatic wait_drained();
    while (msg_bytes_q.size() != 0 || data_valid || parity_expect_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Driver: message beats
  // ---------------------------------------------------------------------
  // Valid rises only when the previous beat is gone (or none was pending),
  // so valid and byte hold steady while ready is low. The prediction runs
  // on the beat taken at this edge, using the pre-edge byte.
  always @(posedge clk) begin
    if (rst) begin
      data_valid <= 1'b0;
      send_gap   <= 0;
    end else begin
      if (data_valid && data_ready) encode_byte(data_byte);
      if (!data_valid || data_ready) begin
        if (send_gap > 0) begin
          data_valid <= 1'b0;
          send_gap   <= send_gap - 1;
        end else if (msg_bytes_q.size() != 0) begin
          data_valid <= 1'b1;
          data_byte  <= msg_bytes_q.pop_front();
          send_gap   <= pick_gap();
        end else begin
          data_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: parity beats, compared in order against the predictions
  // ---------------------------------------------------------------------
  function automatic void check_beat();
    parity_beat_t want;
    beats_seen++;
    if (parity_expect_q.size() == 0) begin
      $error("parity beat with none expected: byte %02h index %0d last %0b",
             parity_byte, parity_index, last_parity);
      mismatch_count++;
      return;
    end
    want = parity_expect_q.pop_front();
    if (parity_byte !== want.sym) begin
      $error("parity_byte: expected %02h, got %02h", want.sym, parity_byte);
      mismatch_count++;
    end
    if (parity_index !== want.pos) begin
      $error("parity_index: expected %0d, got %0d", want.pos, parity_index);
      mismatch_count++;
    end
    if (last_parity !== want.tail) begin
      $error("last_parity: expected %0b, got %0b", want.tail, last_parity);
      mismatch_count++;
    end
  endfunction

  // Receiver back-pressure: ready drops for a random stall after any cycle.
  always @(posedge clk) begin
    if (rst) begin
      parity_ready <= 1'b0;
      recv_stall   <= 0;
    end else begin
      if (parity_valid && parity_ready) check_beat();
      if (recv_stall > 0) begin
        parity_ready <= 1'b0;
        recv_stall   <= recv_stall - 1;
      end else begin
        parity_ready <= 1'b1;
        recv_stall   <= pick_gap();
      end
    end
  end

  // Watchdog: any handshake on either channel restarts the count.
  always @(posedge clk) begin
    if (rst || (data_valid && data_ready) || (parity_valid && parity_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d parity beats outstanding",
               STALL_LIMIT, parity_expect_q.size());
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin
    int         phase;
    logic [2:0] pick;

    build_field();
    reg_pairs  = RST_CHECK_PAIRS;
    reg_root   = RST_FIRST_ROOT;
    reg_length = RST_MESSAGE_LENGTH;
    foreach (lfsr_stage[k]) lfsr_stage[k] = 8'h00;
    msg_count = 0;
    rebuild_generator();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part.
    // Reset generator (t=16, b0=0) kept; only the length shortened.
    burst_mode = ($urandom_range(0, 1) == 0);
    write_reg(CFG_MESSAGE_LENGTH, 8'd2);
    feed(8'h00);
    feed(8'hFF);
    wait_drained();

    // Smallest code: every byte is a codeword with two parity beats.
    burst_mode = ($urandom_range(0, 1) == 0);
    set_code(8'd1, 8'd0, 8'd1);
    feed(8'hFF);
    feed(8'h00);
    feed(8'h80);
    wait_drained();

    // Zero t and zero length clamp to one; root 255 wraps to alpha^0.
    set_code(8'd0, 8'd255, 8'd0);
    feed(8'h01);
    feed(8'hA5);
    wait_drained();

    // t above the maximum clamps to 16; highest legal root.
    set_code(8'd31, 8'd254, 8'd3);
    feed(8'h55);
    feed(8'hAA);
    feed(8'h01);
    wait_drained();

    // Write to the unmapped index, then a mid-size code.
    write_reg(CFG_SPARE, 8'hFF);
    set_code(8'd8, 8'd1, 8'd4);
    feed(8'h80);
    feed(8'h7F);
    feed(8'hFE);
    feed(8'h01);
    wait_drained();

    // Random part: each phase rewrites some registers while idle, then
    // sends whole codewords. One phase asks for length 255, which clamps
    // to 255 - 2t and gives the longest codeword of the run.
    phase = 0;
    while (items_queued < ITEM_TARGET) begin
      phase++;
      burst_mode = ($urandom_range(0, 4) == 0);
      if (phase == 3) begin
        write_reg(CFG_CHECK_PAIRS, ($urandom_range(0, 1) == 0) ? 8'd1 : 8'd16);
        write_reg(CFG_MESSAGE_LENGTH, 8'd255);
        queue_codewords(1);
      end else begin
        pick = 3'($urandom_range(1, 7));
        if (pick[0]) write_reg(CFG_CHECK_PAIRS, {3'($urandom_range(0, 7)), pick_pairs()});
        if (pick[1]) write_reg(CFG_FIRST_ROOT, 8'($urandom_range(0, 255)));
        if (pick[2]) write_reg(CFG_MESSAGE_LENGTH, pick_length());
        if ($urandom_range(0, 9) == 0) write_reg(CFG_SPARE, 8'($urandom_range(0, 255)));
        queue_codewords($urandom_range(1, 4));
      end
      wait_drained();
    end

    // Extra cycles catch any stray parity beat after the last codeword.
    repeat (40) @(posedge clk);
    $display("run covered %0d message bytes in %0d codewords, %0d register writes",
             items_queued, codewords_done, config_writes);
    $display("%0d parity beats checked, %0d field mismatches", beats_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
